// ----- design/hhfl_pkg.sv -----
// Package with the phase type, byte codes and key tables of the HTTP header field locator.
`default_nettype none
package hhfl_pkg;

  localparam int unsigned MaxPayloadDefault = 65535;
  localparam int unsigned PosW = 16;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_KEY   = 2'd1,
    PH_VALUE = 2'd2,
    PH_DONE  = 2'd3
  } phase_t;

  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [1:0] MethodGet     = 2'd0;
  localparam logic [1:0] MethodUnknown = 2'd3;

  // Start tokens: 0 HTTP/1.1, 1 GET, 2 HEAD, 3 POST.
  function automatic logic [7:0] start_char(input logic [1:0] k, input logic [3:0] i);
    logic [63:0] s;
    case (k)
      2'd0: s = "HTTP/1.1";
      2'd1: s = {"GET", 40'd0};
      2'd2: s = {"HEAD", 32'd0};
      default: s = {"POST", 32'd0};
    endcase
    start_char = s[63 - 8 * i[2:0] -: 8];
  endfunction

  function automatic logic [3:0] start_len(input logic [1:0] k);
    case (k)
      2'd0: start_len = 4'd8;
      2'd1: start_len = 4'd3;
      default: start_len = 4'd4;
    endcase
  endfunction

  // Keys including the colon: 0 Host:, 1 User-Agent:, 2 Content-Type:.
  function automatic logic [7:0] key_char(input logic [1:0] k, input logic [3:0] i);
    logic [103:0] s;
    case (k)
      2'd0: s = {"Host:", 64'd0};
      2'd1: s = {"User-Agent:", 16'd0};
      default: s = "Content-Type:";
    endcase
    key_char = (i < 4'd13) ? s[103 - 8 * i -: 8] : 8'd0;
  endfunction

  function automatic logic [3:0] key_len(input logic [1:0] k);
    case (k)
      2'd0: key_len = 4'd5;
      2'd1: key_len = 4'd11;
      default: key_len = 4'd13;
    endcase
  endfunction

  typedef struct packed {
    logic       ok;
    logic       resp;
    logic [1:0] method;
    logic [15:0] status;
    logic [15:0] uri_off;
    logic [15:0] uri_len;
    logic [15:0] host_off;
    logic [15:0] host_len;
    logic [15:0] agent_off;
    logic [15:0] agent_len;
    logic [15:0] ctype_off;
    logic [15:0] ctype_len;
  } result_t;

endpackage
`default_nettype wire

// ----- design/hhfl_scan.sv -----
// Per-byte parser state: start line, header keys and value positions.
`default_nettype none
module hhfl_scan
  import hhfl_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDefault
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       step,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output result_t         result
);

  logic [PosW-1:0] pos_r, pos_nxt;
  phase_t          phase_r, phase_nxt;
  logic            cr_r, cr_nxt, colon_r, colon_nxt;
  logic [1:0]      sp_r, sp_nxt;
  logic [3:0]      tok_r, tok_nxt;
  logic [3:0]      idx_r, idx_nxt;
  logic [15:0]     stat_r, stat_nxt;
  logic            dig_r, dig_nxt;
  logic [2:0]      key_r, key_nxt;
  logic [15:0]     vst_r, vst_nxt, vend_r, vend_nxt, sp1_r, sp1_nxt;
  logic            vseen_r, vseen_nxt;
  logic [15:0]     f_r [8];
  logic [15:0]     f_nxt [8];
  logic [3:0]      fl_r, fl_nxt;

  // Combinational update of the parser for one byte.
  always_comb begin
    logic        lf, sp, in_range;
    logic [1:0]  kind;
    logic [2:0]  hit;
    logic [15:0] vend;
    pos_nxt = pos_r; phase_nxt = phase_r; cr_nxt = cr_r; colon_nxt = colon_r;
    sp_nxt = sp_r; tok_nxt = tok_r; idx_nxt = idx_r; stat_nxt = stat_r; dig_nxt = dig_r;
    key_nxt = key_r; vst_nxt = vst_r; vend_nxt = vend_r; sp1_nxt = sp1_r;
    vseen_nxt = vseen_r; fl_nxt = fl_r;
    for (int i = 0; i < 8; i++) f_nxt[i] = f_r[i];
    lf = cr_r && (data_byte == ChLf);
    sp = data_byte == ChSpace;
    kind = MethodUnknown;
    hit = 3'd0;
    vend = vseen_r ? vend_r : pos_r - 16'd1;
    in_range = 32'(pos_r) < MAX_PAYLOAD;
    if (in_range) begin
      case (phase_r)
        PH_START: begin
          if (lf) begin
            if (sp_r == 2'd2 && (!fl_r[1] || dig_r)) begin
              fl_nxt[0] = 1'b1;
              if (fl_r[1]) begin
                f_nxt[0] = '0; f_nxt[1] = '0;
              end
              phase_nxt = PH_KEY;
              key_nxt = 3'b111; idx_nxt = '0; vst_nxt = '0; vseen_nxt = 1'b0; vend_nxt = '0;
            end else begin
              fl_nxt = '0; f_nxt[0] = '0; f_nxt[1] = '0;
              phase_nxt = PH_DONE;
            end
          end else if (sp) begin
            if (sp_r == 2'd0) begin
              for (int k = 3; k >= 1; k--)
                if (tok_r[k] && idx_r == start_len(2'(k))) kind = 2'(k - 1);
              if (tok_r[0] && idx_r == start_len(2'd0)) fl_nxt = 4'b0010;
              else fl_nxt = {kind, 2'b00};
              sp1_nxt = pos_r;
              f_nxt[0] = pos_r + 16'd1;
              idx_nxt = '0;
              sp_nxt = 2'd1;
            end else if (sp_r == 2'd1) begin
              f_nxt[1] = pos_r - sp1_r - 16'd1;
              sp_nxt = 2'd2;
            end
          end else if (sp_r == 2'd0) begin
            for (int k = 0; k < 4; k++)
              if (idx_r >= start_len(2'(k)) || start_char(2'(k), idx_r) != data_byte)
                tok_nxt[k] = 1'b0;
            if (idx_r != 4'd15) idx_nxt = idx_r + 4'd1;
          end else if (sp_r == 2'd1 && fl_r[1] && idx_r == 4'd0) begin
            if (data_byte >= ChZero && data_byte <= ChNine) begin
              stat_nxt = {stat_r[12:0], 3'b000} + {stat_r[14:0], 1'b0}
                         + {12'd0, data_byte[3:0]};
              dig_nxt = 1'b1;
            end else begin
              idx_nxt = 4'd1;
            end
          end
        end
        PH_KEY, PH_VALUE: begin
          if (lf) begin
            if (phase_r == PH_KEY) begin
              if (idx_r == 4'd1) phase_nxt = PH_DONE;
            end else begin
              for (int k = 0; k < 3; k++)
                if (key_r[k]) begin
                  f_nxt[2 + 2 * k] = vst_r;
                  f_nxt[3 + 2 * k] = vend - vst_r;
                end
              phase_nxt = PH_KEY;
            end
            key_nxt = 3'b111; idx_nxt = '0; vst_nxt = '0; vseen_nxt = 1'b0; vend_nxt = '0;
          end else if (phase_r == PH_KEY) begin
            if (colon_r && sp) begin
              for (int k = 0; k < 3; k++)
                if (key_r[k] && idx_r == key_len(2'(k))) hit = 3'(1 << k);
              key_nxt = hit;
              vst_nxt = pos_r + 16'd1;
              phase_nxt = PH_VALUE;
            end else begin
              for (int k = 0; k < 3; k++)
                if (idx_r >= key_len(2'(k)) || key_char(2'(k), idx_r) != data_byte)
                  key_nxt[k] = 1'b0;
              if (idx_r != 4'd15) idx_nxt = idx_r + 4'd1;
            end
          end else if (!vseen_r && colon_r && sp) begin
            vend_nxt = pos_r - 16'd1;
            vseen_nxt = 1'b1;
          end
        end
        default: ;
      endcase
      cr_nxt = data_byte == ChCr;
      if (phase_nxt != PH_START && phase_nxt != PH_DONE && !(lf))
        colon_nxt = data_byte == ChColon;
      else
        colon_nxt = 1'b0;
      if (phase_r != PH_START && phase_r != PH_DONE && lf) colon_nxt = 1'b0;
      pos_nxt = pos_r + 16'd1;
    end
    // Report, then return to the reset state.
    result = '0;
    if (phase_nxt != PH_START && fl_nxt[0]) begin
      result.ok = 1'b1;
      result.resp = fl_nxt[1];
      result.method = fl_nxt[1] ? MethodGet : fl_nxt[3:2];
      result.status = fl_nxt[1] ? stat_nxt : '0;
      result.uri_off = f_nxt[0];   result.uri_len = f_nxt[1];
      result.host_off = f_nxt[2];  result.host_len = f_nxt[3];
      result.agent_off = f_nxt[4]; result.agent_len = f_nxt[5];
      result.ctype_off = f_nxt[6]; result.ctype_len = f_nxt[7];
    end
  end

  // State registers; cleared at reset and at the end of each payload.
  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      pos_r <= '0; phase_r <= PH_START; cr_r <= 1'b0; colon_r <= 1'b0; sp_r <= '0;
      tok_r <= 4'hf; idx_r <= '0; stat_r <= '0; dig_r <= 1'b0; key_r <= 3'b111;
      vst_r <= '0; vend_r <= '0; sp1_r <= '0; vseen_r <= 1'b0; fl_r <= '0;
      for (int i = 0; i < 8; i++) f_r[i] <= '0;
    end else if (step) begin
      pos_r <= pos_nxt; phase_r <= phase_nxt; cr_r <= cr_nxt; colon_r <= colon_nxt;
      sp_r <= sp_nxt; tok_r <= tok_nxt; idx_r <= idx_nxt; stat_r <= stat_nxt;
      dig_r <= dig_nxt; key_r <= key_nxt; vst_r <= vst_nxt; vend_r <= vend_nxt;
      sp1_r <= sp1_nxt; vseen_r <= vseen_nxt; fl_r <= fl_nxt;
      for (int i = 0; i < 8; i++) f_r[i] <= f_nxt[i];
    end
  end

`ifndef SYNTHESIS
  a_stat_zero_req: assert property (@(posedge clk) disable iff (!rst_n)
    !(result.ok && !result.resp) || result.status == 16'd0)
    else $error("status set on a request");
  a_resp_no_uri: assert property (@(posedge clk) disable iff (!rst_n)
    !result.resp || (result.uri_off == 16'd0 && result.uri_len == 16'd0))
    else $error("uri set on a response");
  a_done_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DONE && !(step && last_byte)) |=> phase_r == PH_DONE)
    else $error("left done phase within payload");
`endif

endmodule
`default_nettype wire

// ----- design/http_header_field_locator.sv -----
// Top level of the HTTP header field locator: input register, parser and result register.
// Usage: payload bytes arrive on in_data_byte with in_last_byte marking the final byte;
// a transaction completes when in_valid is high and in_stall is low.
// Each accepted byte goes into an input register; the parser updates its state from
// that register, so one byte is taken every cycle, limited only by the output register.
// On the final byte a result transaction carrying offsets and lengths of the URI and
// the Host, User-Agent and Content-Type values is loaded into the result register and
// shown on the out_ ports when the parser takes that byte; other bytes give none.
// When the receiver raises out_stall the result is held; a final byte in the input
// register then waits behind it and in_stall rises while both are full.
// Synchronous reset (rst_n low) empties both registers and clears parser state;
// the parser also clears itself after every final byte, ready for a new payload.
`default_nettype none
module http_header_field_locator
  import hhfl_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = MaxPayloadDefault
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_parse_ok,
  output logic             out_resp_flag,
  output logic [1:0]       out_method_kind,
  output logic [15:0]      out_status_code,
  output logic [15:0]      out_uri_offset,
  output logic [15:0]      out_uri_length,
  output logic [15:0]      out_host_offset,
  output logic [15:0]      out_host_length,
  output logic [15:0]      out_agent_offset,
  output logic [15:0]      out_agent_length,
  output logic [15:0]      out_ctype_offset,
  output logic [15:0]      out_ctype_length
);

  logic       iv_r;
  logic [7:0] ib_r;
  logic       il_r;
  logic       ov_r;
  result_t    res_r, res;
  logic       step, out_free, in_take;

  // The parser advances when the held byte can move on.
  assign out_free = !ov_r || !out_stall;
  assign step     = iv_r && (!il_r || out_free);
  assign in_stall = iv_r && !step;
  assign in_take  = in_valid && !in_stall;

  hhfl_scan #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_scan (
    .clk(clk), .rst_n(rst_n), .step(step),
    .data_byte(ib_r), .last_byte(il_r), .result(res)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (in_take) begin
      iv_r <= 1'b1;
    end else if (step) begin
      iv_r <= 1'b0;
    end
    if (in_take) begin
      ib_r <= in_data_byte;
      il_r <= in_last_byte;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (step && il_r) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
    if (step && il_r) begin
      res_r <= res;
    end
  end

  assign out_valid        = ov_r;
  assign out_parse_ok     = res_r.ok;
  assign out_resp_flag    = res_r.resp;
  assign out_method_kind  = res_r.method;
  assign out_status_code  = res_r.status;
  assign out_uri_offset   = res_r.uri_off;
  assign out_uri_length   = res_r.uri_len;
  assign out_host_offset  = res_r.host_off;
  assign out_host_length  = res_r.host_len;
  assign out_agent_offset = res_r.agent_off;
  assign out_agent_length = res_r.agent_len;
  assign out_ctype_offset = res_r.ctype_off;
  assign out_ctype_length = res_r.ctype_len;

`ifndef SYNTHESIS
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid && $stable(res_r))
    else $error("stalled result changed");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |-> !(step && il_r))
    else $error("result overwritten");
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> iv_r)
    else $error("stall with empty input register");
`endif

endmodule
`default_nettype wire

// ----- bench/http_header_field_locator_checker.sv -----
// Checker for the HTTP header field locator: predicts each result and compares it.
`timescale 1ns / 100ps
`default_nettype none
module http_header_field_locator_checker
  import hhfl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic        out_parse_ok,
  input  wire logic        out_resp_flag,
  input  wire logic [1:0]  out_method_kind,
  input  wire logic [15:0] out_status_code,
  input  wire logic [15:0] out_uri_offset,
  input  wire logic [15:0] out_uri_length,
  input  wire logic [15:0] out_host_offset,
  input  wire logic [15:0] out_host_length,
  input  wire logic [15:0] out_agent_offset,
  input  wire logic [15:0] out_agent_length,
  input  wire logic [15:0] out_ctype_offset,
  input  wire logic [15:0] out_ctype_length,
  output int               fail_count,
  output int               pending_count,
  output int               result_count,
  output int               response_count
);

  localparam int unsigned PayloadCap = MaxPayloadDefault;

  // Parser state as the predictor keeps it.
  logic [31:0] pos_q;
  phase_t      phase_q;
  logic        cr_q, colon_q;
  logic [1:0]  spaces_q;
  logic [3:0]  start_hits_q;
  logic [3:0]  char_idx_q;
  logic [15:0] status_q;
  logic        digit_q;
  logic [2:0]  key_hits_q;
  logic [31:0] val_start_q;
  logic        val_end_q;
  logic [31:0] val_end_pos_q;
  logic [31:0] first_space_q;
  logic [15:0] fields_q [8];
  logic [3:0]  flags_q;

  result_t expected_results[$];

  function automatic logic [7:0] start_tok_char(int k, int i);
    string s;
    case (k)
      0: s = "HTTP/1.1";
      1: s = "GET";
      2: s = "HEAD";
      default: s = "POST";
    endcase
    return (i < s.len()) ? s[i] : 8'd0;
  endfunction

  function automatic logic [7:0] key_tok_char(int k, int i);
    string s;
    case (k)
      0: s = "Host:";
      1: s = "User-Agent:";
      default: s = "Content-Type:";
    endcase
    return (i < s.len()) ? s[i] : 8'd0;
  endfunction

  function automatic int start_tok_len(int k);
    return (k == 0) ? 8 : (k == 1) ? 3 : 4;
  endfunction

  function automatic int key_tok_len(int k);
    return (k == 0) ? 5 : (k == 1) ? 11 : 13;
  endfunction

  task automatic clear_parser();
    pos_q = 0; phase_q = PH_START; cr_q = 0; colon_q = 0; spaces_q = 0;
    start_hits_q = 4'hf; char_idx_q = 0; status_q = 0; digit_q = 0;
    key_hits_q = 3'h7; val_start_q = 0; val_end_q = 0; val_end_pos_q = 0;
    first_space_q = 0; flags_q = 0;
    for (int i = 0; i < 8; i++) fields_q[i] = 0;
  endtask

  task automatic new_line();
    key_hits_q = 3'h7; char_idx_q = 0; val_start_q = 0; val_end_q = 0;
    val_end_pos_q = 0; colon_q = 0;
  endtask

  // Start line handling for one byte.
  task automatic start_line_byte(logic [7:0] b, logic [31:0] p);
    logic resp;
    logic [1:0] kind;
    resp = flags_q[1];
    if (cr_q && b == ChLf) begin
      if (spaces_q >= 2 && (!resp || digit_q)) begin
        flags_q[0] = 1'b1;
        if (resp) begin
          fields_q[0] = 0; fields_q[1] = 0;
        end
        phase_q = PH_KEY;
        new_line();
      end else begin
        flags_q = 0; fields_q[0] = 0; fields_q[1] = 0; phase_q = PH_DONE;
      end
    end else if (b == ChSpace) begin
      if (spaces_q == 0) begin
        kind = MethodUnknown;
        for (int k = 3; k >= 1; k--)
          if (start_hits_q[k] && char_idx_q == start_tok_len(k)) kind = 2'(k - 1);
        if (start_hits_q[0] && char_idx_q == 8) flags_q = 4'b0010;
        else flags_q = {kind, 2'b00};
        first_space_q = p;
        fields_q[0] = 16'(p + 1);
        char_idx_q = 0;
        spaces_q = 1;
      end else if (spaces_q == 1) begin
        fields_q[1] = 16'(p - first_space_q - 1);
        spaces_q = 2;
      end
    end else if (spaces_q == 0) begin
      for (int k = 0; k < 4; k++)
        if (start_hits_q[k] && (char_idx_q >= start_tok_len(k) ||
                                start_tok_char(k, char_idx_q) != b))
          start_hits_q[k] = 1'b0;
      if (char_idx_q < 15) char_idx_q++;
    end else if (spaces_q == 1 && resp && char_idx_q == 0) begin
      if (b >= ChZero && b <= ChNine) begin
        status_q = 16'(status_q * 10 + (b - ChZero));
        digit_q = 1'b1;
      end else begin
        char_idx_q = 1;
      end
    end
  endtask

  // Header line handling for one byte.
  task automatic header_line_byte(logic [7:0] b, logic [31:0] p);
    logic [31:0] stop;
    logic [2:0] hit;
    if (cr_q && b == ChLf) begin
      if (phase_q == PH_KEY) begin
        if (char_idx_q == 1) phase_q = PH_DONE;
      end else begin
        stop = val_end_q ? val_end_pos_q : p - 1;
        for (int k = 0; k < 3; k++)
          if (key_hits_q[k]) begin
            fields_q[2 + 2 * k] = 16'(val_start_q);
            fields_q[3 + 2 * k] = 16'(stop - val_start_q);
          end
        phase_q = PH_KEY;
      end
      new_line();
    end else if (phase_q == PH_KEY) begin
      if (colon_q && b == ChSpace) begin
        hit = 0;
        for (int k = 0; k < 3; k++)
          if (key_hits_q[k] && char_idx_q == key_tok_len(k)) hit = 3'(1 << k);
        key_hits_q = hit;
        val_start_q = p + 1;
        phase_q = PH_VALUE;
      end else begin
        for (int k = 0; k < 3; k++)
          if (key_hits_q[k] && (char_idx_q >= key_tok_len(k) ||
                                key_tok_char(k, char_idx_q) != b))
            key_hits_q[k] = 1'b0;
        if (char_idx_q < 15) char_idx_q++;
      end
    end else if (!val_end_q && colon_q && b == ChSpace) begin
      val_end_pos_q = p - 1;
      val_end_q = 1'b1;
    end
  endtask

  // Advances the predictor by one byte and queues a result on the final byte.
  task automatic predict_byte(logic [7:0] b, logic last);
    logic [31:0] p;
    result_t r;
    if (pos_q < PayloadCap) begin
      p = pos_q;
      if (phase_q == PH_START) start_line_byte(b, p);
      else if (phase_q != PH_DONE) header_line_byte(b, p);
      cr_q = (b == ChCr);
      if (phase_q != PH_START && phase_q != PH_DONE && !(!cr_q && b == ChLf))
        colon_q = (b == ChColon);
      else
        colon_q = 1'b0;
      pos_q = p + 1;
    end
    if (last) begin
      r = '0;
      if (phase_q != PH_START && flags_q[0]) begin
        r.ok = 1'b1;
        r.resp = flags_q[1];
        r.method = flags_q[1] ? MethodGet : flags_q[3:2];
        r.status = flags_q[1] ? status_q : 16'd0;
        r.uri_off = fields_q[0];   r.uri_len = fields_q[1];
        r.host_off = fields_q[2];  r.host_len = fields_q[3];
        r.agent_off = fields_q[4]; r.agent_len = fields_q[5];
        r.ctype_off = fields_q[6]; r.ctype_len = fields_q[7];
      end
      expected_results = {expected_results, r};
      clear_parser();
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Compares one result transaction with the oldest expectation.
  task automatic check_result();
    result_t w;
    if (expected_results.size() == 0) begin
      $display("[%0t] result transaction with nothing expected", $realtime);
      fail_count++;
      return;
    end
    w = expected_results.pop_front();
    result_count++;
    if (w.resp) response_count++;
    if (out_parse_ok != w.ok) report_mismatch("parse_ok", out_parse_ok, w.ok);
    if (out_resp_flag != w.resp) report_mismatch("resp_flag", out_resp_flag, w.resp);
    if (out_method_kind != w.method) report_mismatch("method_kind", out_method_kind, w.method);
    if (out_status_code != w.status) report_mismatch("status_code", out_status_code, w.status);
    if (out_uri_offset != w.uri_off) report_mismatch("uri_offset", out_uri_offset, w.uri_off);
    if (out_uri_length != w.uri_len) report_mismatch("uri_length", out_uri_length, w.uri_len);
    if (out_host_offset != w.host_off)
      report_mismatch("host_offset", out_host_offset, w.host_off);
    if (out_host_length != w.host_len)
      report_mismatch("host_length", out_host_length, w.host_len);
    if (out_agent_offset != w.agent_off)
      report_mismatch("agent_offset", out_agent_offset, w.agent_off);
    if (out_agent_length != w.agent_len)
      report_mismatch("agent_length", out_agent_length, w.agent_len);
    if (out_ctype_offset != w.ctype_off)
      report_mismatch("ctype_offset", out_ctype_offset, w.ctype_off);
    if (out_ctype_length != w.ctype_len)
      report_mismatch("ctype_length", out_ctype_length, w.ctype_len);
  endtask

  initial begin
    fail_count = 0;
    result_count = 0;
    response_count = 0;
    clear_parser();
  end

  // Sample both channels at each rising edge, before the drivers update.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) predict_byte(in_data_byte, in_last_byte);
    end
    pending_count = expected_results.size();
  end

endmodule
`default_nettype wire

// ----- bench/http_header_field_locator_test.sv -----
// Testbench top of the HTTP header field locator: stimulus, reset and verdict.
`timescale 1ns / 100ps
`default_nettype none
module http_header_field_locator_test;
  import hhfl_pkg::*;

  logic        clk, rst_n;
  logic        in_valid, in_stall, in_last_byte;
  logic [7:0]  in_data_byte;
  logic        out_valid, out_stall;
  logic        out_parse_ok, out_resp_flag;
  logic [1:0]  out_method_kind;
  logic [15:0] out_status_code, out_uri_offset, out_uri_length;
  logic [15:0] out_host_offset, out_host_length, out_agent_offset, out_agent_length;
  logic [15:0] out_ctype_offset, out_ctype_length;
  int          fail_count, pending_count, result_count, response_count;
  int          cycle_count;
  int          bytes_sent;
  logic        quiet_phase;

  localparam int CycleLimit = 400000;

  http_header_field_locator dut (.*);

  http_header_field_locator_checker checker_inst (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run-length guard.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout with %0d results outstanding", pending_count);
      $display("FAILURE");
      $finish;
    end
  end

  // The receiver stalls now and then, except during a quiet stretch.
  initial out_stall = 1'b0;
  always @(posedge clk)
    out_stall <= !quiet_phase && ($urandom_range(99) < 12);

  // Sends one byte as a transaction, idling at random beforehand.
  task automatic send_byte(logic [7:0] b, logic last);
    while (!quiet_phase && $urandom_range(99) < 12) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_payload(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  function automatic string pick_word();
    string w;
    case ($urandom_range(9))
      0: w = "GET";
      1: w = "HEAD";
      2: w = "POST";
      3: w = "HTTP/1.1";
      4: w = "Host: ";
      5: w = "User-Agent: ";
      6: w = "Content-Type: ";
      7: w = "\r\n";
      8: w = ": ";
      default: begin
        w = " ";
        w[0] = 8'($urandom_range(255));
      end
    endcase
    return w;
  endfunction

  function automatic string rand_text(int n);
    string s;
    string c;
    s = "";
    for (int i = 0; i < n; i++) begin
      c = " ";
      c[0] = 8'($urandom_range(33, 126));
      s = {s, c};
    end
    return s;
  endfunction

  // Mostly well-formed heads with random content.
  function automatic string make_message();
    string s;
    string keys [4];
    keys = '{"Host", "User-Agent", "Content-Type", "Accept"};
    case ($urandom_range(4))
      0: s = {"HTTP/1.1 ", $sformatf("%0d", $urandom_range(99999)),
              ($urandom_range(3) == 0) ? "" : rand_text($urandom_range(0, 3)), " OK"};
      1: s = {"GET ", rand_text($urandom_range(1, 8)), " HTTP/1.1"};
      2: s = {"HEAD ", rand_text($urandom_range(0, 6)), " HTTP/1.1"};
      3: s = {"POST ", rand_text($urandom_range(1, 6)), " HTTP/1.1"};
      default: s = {rand_text($urandom_range(1, 5)), " /", rand_text(2), " x"};
    endcase
    s = {s, "\r\n"};
    for (int h = $urandom_range(0, 4); h > 0; h--) begin
      s = {s, keys[$urandom_range(3)], ": ", rand_text($urandom_range(0, 6))};
      if ($urandom_range(4) == 0) s = {s, ": ", rand_text(2)};
      s = {s, "\r\n"};
    end
    if ($urandom_range(2) != 0) s = {s, "\r\nbody"};
    return s;
  endfunction

  function automatic string make_noise();
    string s;
    s = "";
    for (int i = $urandom_range(1, 12); i > 0; i--) s = {s, pick_word()};
    return s;
  endfunction

  initial begin
    string directed [$];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = 8'h00;
    in_last_byte = 1'b0;
    quiet_phase = 1'b0;
    bytes_sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed heads: every method, responses, malformed and truncated cases.
    directed = '{
      "GET /a HTTP/1.1\r\nHost: ex\r\nUser-Agent: b: c\r\nContent-Type: t\r\n\r\n",
      "HEAD / x\r\nHost: a\r\nHost: \r\n\r\n",
      "POST /p q\r\nContent-Type: x/y\r\nUser-Agent: u\r\nHost",
      "HTTP/1.1 99999 Big\r\nHost: h\r\n\r\n",
      "HTTP/1.1 x200 Bad\r\n\r\n",
      "PUT /z y\r\nhost: lower\r\n\r\n",
      "GET /nocrlf HTTP/1.1",
      "GET /one\r\n\r\n",
      "\xff\x00 \x80 \x7f\r\n",
      "GETX a b\r\nNoColon\r\nHost: v\r\n\r\nHost: after\r\n",
      "x"
    };
    foreach (directed[i]) send_payload(directed[i]);

    // Random part: well-formed heads, noise, and a quiet stretch in the middle.
    while (bytes_sent < 1950) begin
      quiet_phase = (bytes_sent > 900 && bytes_sent < 1200);
      if ($urandom_range(4) == 0) send_payload(make_noise());
      else send_payload(make_message());
    end
    quiet_phase = 1'b0;
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d bytes; checked %0d results, %0d of them responses.",
             bytes_sent, result_count, response_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire
